// ----- hw/rtl/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and phase tables for the stepper phase sequencer.
// ----------------------------------------------------------------------------
package sps_pkg;

  localparam int POS_W   = 32;
  localparam int COUNT_W = 16;
  localparam int COIL_W  = 4;
  localparam int MODE_W  = 2;
  localparam int OP_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_STEP = 2'd1,
    OP_MOVE = 2'd2
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_WAVE = 2'd0,
    MODE_FULL = 2'd1,
    MODE_HALF = 2'd2
  } mode_t;

  typedef logic [COIL_W-1:0] coil_t;

  function automatic coil_t wave_phase(input logic [1:0] idx);
    coil_t c;
    case (idx)
      2'd0:    c = 4'h1;
      2'd1:    c = 4'h2;
      2'd2:    c = 4'h4;
      default: c = 4'h8;
    endcase
    return c;
  endfunction

  function automatic coil_t full_phase(input logic [1:0] idx);
    coil_t c;
    case (idx)
      2'd0:    c = 4'h3;
      2'd1:    c = 4'h6;
      2'd2:    c = 4'hC;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

  function automatic coil_t half_phase(input logic [2:0] idx);
    coil_t c;
    case (idx)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      default: c = 4'h9;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/sps_if.sv -----
// ----------------------------------------------------------------------------
// sps_if
// Valid/ready channels of the stepper phase sequencer: command, result and
// drive mode write.
// ----------------------------------------------------------------------------
interface sps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic               clockwise;
  logic signed [15:0] move_count;

  modport source (output valid, opcode, clockwise, move_count, input ready);
  modport sink   (input valid, opcode, clockwise, move_count, output ready);
endinterface

interface sps_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         coil_pattern;
  logic signed [31:0] step_position;
  logic               moving;

  modport source (output valid, coil_pattern, step_position, moving, input ready);
  modport sink   (input valid, coil_pattern, step_position, moving, output ready);
endinterface

interface sps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] drive_mode;

  modport source (output valid, drive_mode, input ready);
  modport sink   (input valid, drive_mode, output ready);
endinterface

// ----- hw/rtl/stepper_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Four-coil unipolar stepper sequencer with wave, full and half step drive.
// ----------------------------------------------------------------------------
// Takes one request per clock and returns its result in the next cycle from
// the output register; a request is taken whenever that register is empty
// or being drained and no mode write is offered, so throughput is one
// request per cycle. The position update, move compare and phase table
// lookup all settle combinationally between the state registers and the
// result register. Mode writes are always taken, hold off requests in the
// cycle they are offered, and end any move in progress.
module stepper_phase_sequencer
  import sps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  sps_in_if.sink     in_ch,
  sps_out_if.source  out_ch,
  sps_cfg_if.sink    cfg_ch
);

  logic signed [POS_W-1:0] pos_r, pos_nxt;
  logic signed [POS_W-1:0] target_r, target_nxt;
  logic                    move_active_r, move_active_nxt;
  logic [MODE_W-1:0]       mode_r;

  logic                    out_valid_r;
  coil_t                   coil_r, coil_nxt;
  logic signed [POS_W-1:0] step_pos_r, step_pos_nxt;
  logic                    moving_r;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    half_mode;
  logic signed [POS_W-1:0] inc;
  logic signed [POS_W-1:0] pos_up;
  logic signed [POS_W-1:0] pos_dn;
  logic signed [POS_W-1:0] count_ext;
  logic signed [POS_W-1:0] delta;
  logic signed [POS_W-1:0] halved;
  logic                    below;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign cfg_acc   = cfg_ch.valid && cfg_ch.ready;
  assign half_mode = mode_r[1];
  assign inc       = half_mode ? POS_W'(1) : POS_W'(2);
  assign pos_up    = pos_r + inc;
  assign pos_dn    = pos_r - inc;
  assign below     = pos_r < target_r;
  assign count_ext = POS_W'(in_ch.move_count);
  assign delta     = half_mode ? count_ext : (count_ext <<< 1);

  assign in_ch.ready  = (!out_valid_r || out_ch.ready) && !cfg_ch.valid;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    pos_nxt         = pos_r;
    target_nxt      = target_r;
    move_active_nxt = move_active_r;
    case (op_t'(in_ch.opcode))
      OP_TICK: begin
        if (move_active_r) begin
          if (below) begin
            pos_nxt = pos_up;
            if (pos_up >= target_r) begin
              move_active_nxt = 1'b0;
            end
          end else begin
            pos_nxt = pos_dn;
            if (pos_dn <= target_r) begin
              move_active_nxt = 1'b0;
            end
          end
        end
      end
      OP_STEP: begin
        move_active_nxt = 1'b0;
        pos_nxt         = in_ch.clockwise ? pos_up : pos_dn;
      end
      OP_MOVE: begin
        move_active_nxt = 1'b0;
        if (in_ch.move_count != '0) begin
          target_nxt      = pos_r + delta;
          move_active_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // halve toward zero
  assign halved = $signed(pos_nxt + POS_W'(pos_nxt[POS_W-1])) >>> 1;

  always_comb begin
    if (half_mode) begin
      coil_nxt     = half_phase(pos_nxt[2:0]);
      step_pos_nxt = pos_nxt;
    end else begin
      coil_nxt     = (mode_t'(mode_r) == MODE_WAVE) ? wave_phase(halved[1:0])
                                                    : full_phase(halved[1:0]);
      step_pos_nxt = halved;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      target_r      <= '0;
      move_active_r <= 1'b0;
      mode_r        <= MODE_WAVE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_acc) begin
        mode_r        <= cfg_ch.drive_mode;
        move_active_r <= 1'b0;
      end else if (in_acc) begin
        pos_r         <= pos_nxt;
        target_r      <= target_nxt;
        move_active_r <= move_active_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      coil_r     <= coil_nxt;
      step_pos_r <= step_pos_nxt;
      moving_r   <= move_active_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.coil_pattern  = coil_r;
  assign out_ch.step_position = step_pos_r;
  assign out_ch.moving        = moving_r;

`ifndef SYNTHESIS
  a_cfg_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_acc |=> !move_active_r)
    else $error("mode write left a move active");

  a_step_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && in_ch.opcode == OP_STEP) |=> !move_active_r)
    else $error("single step left a move active");

  a_idle_tick_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc && in_ch.opcode == OP_TICK && !move_active_r)
      |=> $stable(pos_r))
    else $error("idle tick moved the position");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted request produced no result");

  a_moving_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !cfg_acc) |=> (moving_r == move_active_r))
    else $error("reported moving flag differs from move state");
`endif

endmodule
